FILE: rtl/core/delimited_frame_receiver_assert.svh
// Assertion macros for the checker file of the frame receiver.
`ifndef DELIMITED_FRAME_RECEIVER_ASSERT_SVH
`define DELIMITED_FRAME_RECEIVER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define DFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/dfr_pkg.sv
package dfr_pkg;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 6;

   localparam logic [BYTE_W-1:0] HDR_A  = 8'h01;
   localparam logic [BYTE_W-1:0] HDR_B  = 8'h23;
   localparam logic [BYTE_W-1:0] HDR_C  = 8'h45;
   localparam logic [BYTE_W-1:0] TAIL_A = 8'h67;
   localparam logic [BYTE_W-1:0] TAIL_B = 8'h89;
   localparam logic [BYTE_W-1:0] TAIL_C = 8'hAB;

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_HDR2  = 3'd2,
      PH_HDR3  = 3'd3,
      PH_DATA  = 3'd4,
      PH_TAIL1 = 3'd5,
      PH_TAIL2 = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_DRAIN_RD,
      CTL_DRAIN_WAIT
   } ctl_type;

endpackage

FILE: rtl/core/delimited_frame_receiver.sv
// Delimited frame receiver. Received bytes arrive one per req_ transfer; the
// block hunts for the header 01 01 23 45 (a 23 in the second position also
// counts and skips straight to waiting for 45), then stores every byte in an
// on-chip RAM of STORE_DEPTH entries until the tail 67 89 AB is seen. On the
// closing AB the payload without the tail goes out over rsp_, one byte per
// transfer, in order, with its position, the frame length and a last flag on
// the final byte; a frame with no payload gives a single result with zero
// payload, zero length and the last flag set. A frame whose fill count
// reaches STORE_DEPTH is dropped silently and the hunt restarts. While
// hunting or storing, req_ready is high every cycle. The drain after a
// closing byte holds req_ready low; each result takes a registered RAM read,
// then the load of the output register, and waits while the consumer stalls;
// the next byte is accepted as soon as the last result is in the output
// register, even while it still waits to be taken. The RAM needs no
// clearing: only entries written in the current frame are ever read.
module delimited_frame_receiver #(
   parameter int STORE_DEPTH = 45
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic [5:0] rsp_byte_position,
   output logic [5:0] rsp_frame_length,
   output logic       rsp_last_of_frame
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

   // Receive state.
   dfr_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]      fill_ff, fill_in;

   // Drain control.
   dfr_pkg::ctl_type          ctl_ff, ctl_in;
   logic [dfr_pkg::POS_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic [dfr_pkg::POS_W-1:0] len_ff, len_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [dfr_pkg::BYTE_W-1:0] payload_ff, payload_in;
   logic [dfr_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [dfr_pkg::POS_W-1:0]  flen_ff, flen_in;
   logic                       last_ff, last_in;

   // RAM ports.
   logic                       wr_en, rd_en;
   logic [AW-1:0]              wr_addr, rd_addr;
   logic [dfr_pkg::BYTE_W-1:0] wr_data, rd_data;

   logic       store;
   logic       slot_free;
   logic       drain_last;
   logic [6:0] fill_wide;
   logic [6:0] len_wide;

   dfr_ram #(
      .WIDTH (dfr_pkg::BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dfr_pkg::PH_HDR0;
         fill_ff      <= '0;
         ctl_ff       <= dfr_pkg::CTL_IDLE;
         rd_cnt_ff    <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         ctl_ff       <= ctl_in;
         rd_cnt_ff    <= rd_cnt_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      pos_ff     <= pos_in;
      flen_ff    <= flen_in;
      last_ff    <= last_in;
   end

   always_comb begin
      phase_in     = phase_ff;
      fill_in      = fill_ff;
      ctl_in       = ctl_ff;
      rd_cnt_in    = rd_cnt_ff;
      len_in       = len_ff;
      payload_in   = payload_ff;
      pos_in       = pos_ff;
      flen_in      = flen_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;
      wr_addr      = fill_ff[AW-1:0];
      wr_data      = req_rx_byte;
      rd_en        = 1'b0;
      rd_addr      = rd_cnt_ff[AW-1:0];
      store        = 1'b0;
      req_ready    = (ctl_ff == dfr_pkg::CTL_IDLE);
      slot_free    = !rsp_valid_ff || rsp_ready;
      drain_last   = (len_ff == '0) || ((rd_cnt_ff + 6'd1) == len_ff);
      fill_wide    = 7'(fill_ff);
      len_wide     = (fill_wide >= 7'd2) ? (fill_wide - 7'd2) : 7'd0;

      // Drop the output register once its result is taken.
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (ctl_ff)
         dfr_pkg::CTL_IDLE: begin
            if (req_valid) begin
               case (phase_ff)
                  dfr_pkg::PH_HDR0: begin
                     if (req_rx_byte == dfr_pkg::HDR_A) begin
                        phase_in = dfr_pkg::PH_HDR1;
                     end
                  end
                  dfr_pkg::PH_HDR1: begin
                     if (req_rx_byte == dfr_pkg::HDR_A) begin
                        phase_in = dfr_pkg::PH_HDR2;
                     end else if (req_rx_byte == dfr_pkg::HDR_B) begin
                        phase_in = dfr_pkg::PH_HDR3;
                     end else begin
                        phase_in = dfr_pkg::PH_HDR0;
                     end
                  end
                  dfr_pkg::PH_HDR2: begin
                     phase_in = (req_rx_byte == dfr_pkg::HDR_B) ? dfr_pkg::PH_HDR3
                                                                 : dfr_pkg::PH_HDR0;
                  end
                  dfr_pkg::PH_HDR3: begin
                     if (req_rx_byte == dfr_pkg::HDR_C) begin
                        phase_in = dfr_pkg::PH_DATA;
                        fill_in  = '0;
                     end else begin
                        phase_in = dfr_pkg::PH_HDR0;
                     end
                  end
                  dfr_pkg::PH_DATA: begin
                     store = 1'b1;
                     if (req_rx_byte == dfr_pkg::TAIL_A) begin
                        phase_in = dfr_pkg::PH_TAIL1;
                     end
                  end
                  dfr_pkg::PH_TAIL1: begin
                     store    = 1'b1;
                     phase_in = (req_rx_byte == dfr_pkg::TAIL_B) ? dfr_pkg::PH_TAIL2
                                                                 : dfr_pkg::PH_DATA;
                  end
                  dfr_pkg::PH_TAIL2: begin
                     if (req_rx_byte == dfr_pkg::TAIL_C) begin
                        // Frame closed: start the drain of the stored payload.
                        len_in    = len_wide[dfr_pkg::POS_W-1:0];
                        rd_cnt_in = '0;
                        ctl_in    = dfr_pkg::CTL_DRAIN_RD;
                        fill_in   = '0;
                        phase_in  = dfr_pkg::PH_HDR0;
                     end else begin
                        store    = 1'b1;
                        phase_in = dfr_pkg::PH_DATA;
                     end
                  end
                  default: begin
                     fill_in  = '0;
                     phase_in = dfr_pkg::PH_HDR0;
                  end
               endcase

               // Write the byte at the fill count, guarded against a full store.
               if (store && (fill_ff < DEPTH_C)) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + CW'(1);
               end

               // Drop the frame once the store is full.
               if (fill_in == DEPTH_C) begin
                  phase_in = dfr_pkg::PH_HDR0;
                  fill_in  = '0;
               end
            end
         end
         dfr_pkg::CTL_DRAIN_RD: begin
            // Issue the read only when the output register is free at the next edge.
            if (slot_free) begin
               rd_en  = 1'b1;
               ctl_in = dfr_pkg::CTL_DRAIN_WAIT;
            end
         end
         dfr_pkg::CTL_DRAIN_WAIT: begin
            rsp_valid_in = 1'b1;
            payload_in   = (len_ff == '0) ? '0 : rd_data;
            pos_in       = rd_cnt_ff;
            flen_in      = len_ff;
            last_in      = drain_last;
            rd_cnt_in    = rd_cnt_ff + 6'd1;
            ctl_in       = drain_last ? dfr_pkg::CTL_IDLE : dfr_pkg::CTL_DRAIN_RD;
         end
         default: begin
            ctl_in = dfr_pkg::CTL_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_byte  = payload_ff;
   assign rsp_byte_position = pos_ff;
   assign rsp_frame_length  = flen_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

FILE: rtl/core/dfr_ram.sv
module dfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 45
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/dfr_checker.sv
`include "delimited_frame_receiver_assert.svh"

module dfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_payload_byte,
   input logic [5:0] rsp_byte_position,
   input logic [5:0] rsp_frame_length,
   input logic       rsp_last_of_frame
);

   // Hold a stalled result.
   `DFR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_byte_position) && $stable(rsp_last_of_frame), "stalled result changed")

   // The last flag marks the final position of the run.
   `DFR_ASSERT(a_last_pos, clock, reset, rsp_valid && rsp_last_of_frame && (rsp_frame_length != 6'd0) |-> (rsp_byte_position + 6'd1 == rsp_frame_length), "last flag off the final position")

   // Positions stay inside the frame.
   `DFR_ASSERT(a_pos_range, clock, reset, rsp_valid && (rsp_frame_length != 6'd0) |-> (rsp_byte_position < rsp_frame_length) && (rsp_last_of_frame || (rsp_byte_position + 6'd1 != rsp_frame_length)), "position outside the frame")

   // A result of an empty frame is flagged, with zero payload and position.
   `DFR_ASSERT_ALWAYS(a_empty, clock, rsp_valid && !reset && (rsp_frame_length == 6'd0) |-> rsp_last_of_frame && (rsp_payload_byte == 8'd0) && (rsp_byte_position == 6'd0), "empty frame result malformed")

endmodule

bind delimited_frame_receiver dfr_checker u_dfr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_byte_position (rsp_byte_position),
   .rsp_frame_length  (rsp_frame_length),
   .rsp_last_of_frame (rsp_last_of_frame)
);

FILE: dv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 45;
   // Backstop only: a correct run ends far sooner. It allows for every byte
   // draining a full 42-byte frame while the consumer stalls for long stretches.
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int RANDOM_BYTES = 140;

   // One expected transfer on the result channel.
   typedef struct {
      logic [7:0] payload;
      logic [5:0] position;
      logic [5:0] length;
      logic       last;
   } payload_rsp_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic [5:0] rsp_byte_position;
   logic [5:0] rsp_frame_length;
   logic       rsp_last_of_frame;

   // Shadow of the receiver's frame tracking.
   dfr_pkg::phase_type hunt_phase = dfr_pkg::PH_HDR0;
   int         stored_count = 0;
   logic [7:0] stored_bytes [STORE_DEPTH];

   payload_rsp_type payload_due [$];
   payload_rsp_type want;

   int idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int rx_accepted = 0;
   int results_checked = 0;
   int frames_done = 0;
   int empty_frames = 0;
   int dropped_frames = 0;
   int frame_bytes_sent = 0;

   delimited_frame_receiver #(
      .STORE_DEPTH(STORE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_byte_position(rsp_byte_position),
      .rsp_frame_length(rsp_frame_length),
      .rsp_last_of_frame(rsp_last_of_frame)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs or a handshake never completes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results still due",
                  $realtime, cycle_count, payload_due.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   // Append one byte to the frame store; writes past the end are dropped.
   function automatic void store_rx(input logic [7:0] b);
      if (stored_count < STORE_DEPTH) begin
         stored_bytes[stored_count] = b;
         stored_count++;
      end
   endfunction

   // Advance the frame hunt by one accepted byte and queue the payload
   // transfers that the closing byte releases.
   function automatic void advance_frame_hunt(input logic [7:0] b);
      payload_rsp_type r;
      int len;
      case (hunt_phase)
         dfr_pkg::PH_HDR0: begin
            if (b == dfr_pkg::HDR_A) hunt_phase = dfr_pkg::PH_HDR1;
         end
         dfr_pkg::PH_HDR1: begin
            // A 23 here stands in for the repeated 01.
            if (b == dfr_pkg::HDR_A) hunt_phase = dfr_pkg::PH_HDR2;
            else if (b == dfr_pkg::HDR_B) hunt_phase = dfr_pkg::PH_HDR3;
            else hunt_phase = dfr_pkg::PH_HDR0;
         end
         dfr_pkg::PH_HDR2: begin
            hunt_phase = (b == dfr_pkg::HDR_B) ? dfr_pkg::PH_HDR3 : dfr_pkg::PH_HDR0;
         end
         dfr_pkg::PH_HDR3: begin
            if (b == dfr_pkg::HDR_C) begin
               hunt_phase = dfr_pkg::PH_DATA;
               stored_count = 0;
            end else begin
               hunt_phase = dfr_pkg::PH_HDR0;
            end
         end
         dfr_pkg::PH_DATA: begin
            store_rx(b);
            if (b == dfr_pkg::TAIL_A) hunt_phase = dfr_pkg::PH_TAIL1;
         end
         dfr_pkg::PH_TAIL1: begin
            store_rx(b);
            hunt_phase = (b == dfr_pkg::TAIL_B) ? dfr_pkg::PH_TAIL2 : dfr_pkg::PH_DATA;
         end
         dfr_pkg::PH_TAIL2: begin
            if (b == dfr_pkg::TAIL_C) begin
               // The stored 67 89 are not part of the payload.
               len = (stored_count >= 2) ? stored_count - 2 : 0;
               if (len == 0) begin
                  r.payload = 8'h00;
                  r.position = 6'd0;
                  r.length = 6'd0;
                  r.last = 1'b1;
                  payload_due.push_back(r);
                  empty_frames++;
               end else begin
                  for (int k = 0; k < len; k++) begin
                     r.payload = stored_bytes[k];
                     r.position = k[5:0];
                     r.length = len[5:0];
                     r.last = (k + 1 == len);
                     payload_due.push_back(r);
                  end
               end
               frames_done++;
               stored_count = 0;
               hunt_phase = dfr_pkg::PH_HDR0;
            end else begin
               store_rx(b);
               hunt_phase = dfr_pkg::PH_DATA;
            end
         end
         default: begin
            stored_count = 0;
            hunt_phase = dfr_pkg::PH_HDR0;
         end
      endcase
      if (stored_count == STORE_DEPTH) begin
         hunt_phase = dfr_pkg::PH_HDR0;
         stored_count = 0;
         dropped_frames++;
      end
   endfunction

   // Result side: stall at random and compare every transfer with the
   // oldest expectation.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (payload_due.size() == 0) begin
            $display("%0t: unexpected result: payload %h position %0d length %0d last %b",
                     $realtime, rsp_payload_byte, rsp_byte_position, rsp_frame_length,
                     rsp_last_of_frame);
            mismatches++;
         end else begin
            want = payload_due.pop_front();
            results_checked++;
            if (rsp_payload_byte !== want.payload) begin
               $display("%0t: payload_byte expected %h actual %h",
                        $realtime, want.payload, rsp_payload_byte);
               mismatches++;
            end
            if (rsp_byte_position !== want.position) begin
               $display("%0t: byte_position expected %0d actual %0d",
                        $realtime, want.position, rsp_byte_position);
               mismatches++;
            end
            if (rsp_frame_length !== want.length) begin
               $display("%0t: frame_length expected %0d actual %0d",
                        $realtime, want.length, rsp_frame_length);
               mismatches++;
            end
            if (rsp_last_of_frame !== want.last) begin
               $display("%0t: last_of_frame expected %b actual %b",
                        $realtime, want.last, rsp_last_of_frame);
               mismatches++;
            end
         end
      end
   end

   // Offer one byte, idling first at random, and hold it until the transfer.
   // Valid is left high so the next byte can follow without a gap.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      advance_frame_hunt(b);
      rx_accepted++;
   endtask

   // Drop valid and hold off until every queued result has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (payload_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      idle_pct = sender_pct;
      stall_pct = receiver_pct;
   endtask

   task automatic send_header(input bit short_form);
      send_byte(dfr_pkg::HDR_A);
      if (!short_form) send_byte(dfr_pkg::HDR_A);
      send_byte(dfr_pkg::HDR_B);
      send_byte(dfr_pkg::HDR_C);
   endtask

   task automatic send_tail();
      send_byte(dfr_pkg::TAIL_A);
      send_byte(dfr_pkg::TAIL_B);
      send_byte(dfr_pkg::TAIL_C);
   endtask

   // Payload content leaning on the delimiter values so that false tails
   // and stray header bytes turn up inside frames.
   function automatic logic [7:0] pick_payload_byte();
      case ($urandom_range(15))
         0: return dfr_pkg::TAIL_A;
         1: return dfr_pkg::TAIL_B;
         2: return dfr_pkg::TAIL_C;
         3: return dfr_pkg::HDR_A;
         default: return 8'($urandom);
      endcase
   endfunction

   // Header hunt: a third 01 aborts without being taken as a new start,
   // and a wrong byte after 01 23 returns to the hunt.
   task automatic test_header_hunt();
      send_byte(dfr_pkg::HDR_A);
      send_byte(dfr_pkg::HDR_A);
      send_byte(dfr_pkg::HDR_A);
      send_byte(dfr_pkg::HDR_B);
      send_byte(dfr_pkg::HDR_C);
      send_byte(dfr_pkg::HDR_A);
      send_byte(dfr_pkg::HDR_B);
      send_byte(8'h46);
      wait_drained();
   endtask

   // Short header with the tail right behind it: one flagged empty result.
   task automatic test_empty_frame();
      send_header(1'b1);
      send_tail();
      wait_drained();
   endtask

   // False tails: 67 then a non-89, and 67 89 then a non-AB, are both kept
   // as payload and neither restarts tail matching.
   task automatic test_tail_mismatch();
      send_header(1'b0);
      send_byte(8'hFF);
      send_byte(dfr_pkg::TAIL_A);
      send_byte(dfr_pkg::TAIL_A);
      send_byte(dfr_pkg::TAIL_B);
      send_byte(8'h00);
      send_byte(dfr_pkg::TAIL_A);
      send_byte(dfr_pkg::TAIL_B);
      send_byte(dfr_pkg::TAIL_A);
      send_byte(dfr_pkg::TAIL_C);
      send_tail();
      wait_drained();
   endtask

   // Largest frame that fits, then one that overflows and is dropped,
   // then a short frame to show the hunt resumed.
   task automatic test_store_limits();
      logic [7:0] b;
      send_header(1'b0);
      for (int k = 0; k < STORE_DEPTH - 3; k++) begin
         do b = 8'($urandom); while (b == dfr_pkg::TAIL_A);
         send_byte(b);
      end
      send_tail();
      wait_drained();
      send_header(1'b1);
      for (int k = 0; k < STORE_DEPTH + 4; k++) begin
         do b = 8'($urandom); while (b == dfr_pkg::TAIL_A || b == dfr_pkg::HDR_A);
         send_byte(b);
      end
      send_tail();
      send_header(1'b0);
      send_byte(8'h5A);
      send_tail();
      wait_drained();
   endtask

   // One random burst: mostly well-formed frames with random content, the
   // rest noise and broken headers or tails.
   task automatic send_random_burst();
      int kind;
      int len;
      int cut;
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end else if (kind < 16) begin
         cut = $urandom_range(3);
         send_byte(dfr_pkg::HDR_A);
         if (cut >= 1) send_byte(($urandom_range(1) != 0) ? dfr_pkg::HDR_A : dfr_pkg::HDR_B);
         if (cut >= 2) send_byte(dfr_pkg::HDR_B);
         send_byte(8'($urandom));
      end else begin
         send_header($urandom_range(3) == 0);
         cut = $urandom_range(99);
         if (cut < 3) len = STORE_DEPTH - 3;
         else if (cut < 6) len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH - 2);
         else len = $urandom_range(6);
         for (int k = 0; k < len; k++) begin
            send_byte(pick_payload_byte());
            frame_bytes_sent++;
         end
         cut = $urandom_range(9);
         if (cut == 0) begin
            send_byte(dfr_pkg::TAIL_A);
            send_byte(8'($urandom));
         end else if (cut == 1) begin
            send_byte(dfr_pkg::TAIL_A);
            send_byte(dfr_pkg::TAIL_B);
            send_byte(8'($urandom));
         end
         send_tail();
         frame_bytes_sent += 7;
      end
   endtask

   // Random traffic under one idling pattern, then hold off until drained.
   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int byte_count);
      int goal;
      set_idling(sender_pct, receiver_pct);
      goal = frame_bytes_sent + byte_count;
      while (frame_bytes_sent < goal) begin
         send_random_burst();
         // Now and then let the whole backlog drain with the sender paused.
         if ($urandom_range(19) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with no idling on either side before the store limits test.
      set_idling(0, 0);
      test_header_hunt();
      test_empty_frame();
      test_tail_mismatch();
      set_idling(21, 21);
      test_store_limits();

      // Random part across the idling patterns.
      test_random_traffic(0, 0, RANDOM_BYTES / 4);
      test_random_traffic(46, 0, RANDOM_BYTES / 4);
      test_random_traffic(0, 46, RANDOM_BYTES / 4);
      test_random_traffic(21, 21, RANDOM_BYTES / 4);

      // Let the last transfer settle before the final check.
      repeat (20) @(posedge clock);
      if (payload_due.size() != 0) begin
         $display("%0t: %0d expected results never arrived",
                  $realtime, payload_due.size());
         mismatches++;
      end

      $display("Sent %0d bytes; %0d frames closed (%0d empty), %0d dropped on overflow.",
               rx_accepted, frames_done, empty_frames, dropped_frames);
      $display("Checked %0d payload transfers; %0d mismatches.",
               results_checked, mismatches);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
